>>> rtl/lbf_pkg.sv
// Shared types and constants for the LED breathing fade controller.
// Used by lbf_cfg_regs, lbf_step and led_breathing_fade_controller; no dependencies.
package lbf_pkg;

	localparam int unsigned LevelW = 8;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 8;

	localparam logic [LevelW-1:0] LevelTop = 8'hFF;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] RegEnabled = 3'd0;
	localparam logic [CfgIdxW-1:0] RegBrightMax = 3'd1;
	localparam logic [CfgIdxW-1:0] RegBrightMin = 3'd2;
	localparam logic [CfgIdxW-1:0] RegRampStep = 3'd3;
	localparam logic [CfgIdxW-1:0] RegHoldHigh = 3'd4;
	localparam logic [CfgIdxW-1:0] RegHoldLow = 3'd5;

	// Configuration reset values
	localparam logic [LevelW-1:0] BrightMaxRst = 8'd255;
	localparam logic [LevelW-1:0] BrightMinRst = 8'd0;
	localparam logic [LevelW-1:0] RampStepRst = 8'd1;
	localparam logic [LevelW-1:0] HoldHighRst = 8'd255;
	localparam logic [LevelW-1:0] HoldLowRst = 8'd8;

	typedef enum logic [2:0] {
		PH_OFF       = 3'd0,
		PH_UP        = 3'd1,
		PH_HOLD_HIGH = 3'd2,
		PH_DOWN      = 3'd3,
		PH_HOLD_LOW  = 3'd4
	} phase_t;

	typedef struct packed {
		logic              enabled;
		logic [LevelW-1:0] bright_max;
		logic [LevelW-1:0] bright_min;
		logic [LevelW-1:0] ramp_step;
		logic [LevelW-1:0] hold_high_ticks;
		logic [LevelW-1:0] hold_low_ticks;
	} cfg_t;

	typedef struct packed {
		phase_t            phase;
		logic [LevelW-1:0] level;
		logic [LevelW-1:0] tick_count;
		logic              night_seen;
	} state_t;

	typedef struct packed {
		logic [LevelW-1:0] brightness;
		logic              write_brightness;
		logic              new_color;
		phase_t            phase;
	} result_t;

endpackage

>>> rtl/lbf_cfg_regs.sv
// Configuration register file of the LED breathing fade controller.
// Depends on lbf_pkg for register indexes, reset values and cfg_t.
module lbf_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [lbf_pkg::CfgIdxW-1:0]    wr_index,
	input  logic [lbf_pkg::CfgDataW-1:0]   wr_data,
	output lbf_pkg::cfg_t                  cfg
);

	lbf_pkg::cfg_t cfg_q;

	// Write one register per transaction; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled         <= 1'b0;
			cfg_q.bright_max      <= lbf_pkg::BrightMaxRst;
			cfg_q.bright_min      <= lbf_pkg::BrightMinRst;
			cfg_q.ramp_step       <= lbf_pkg::RampStepRst;
			cfg_q.hold_high_ticks <= lbf_pkg::HoldHighRst;
			cfg_q.hold_low_ticks  <= lbf_pkg::HoldLowRst;
		end else if (wr_en) begin
			unique case (wr_index)
				lbf_pkg::RegEnabled:   cfg_q.enabled         <= wr_data[0];
				lbf_pkg::RegBrightMax: cfg_q.bright_max      <= wr_data;
				lbf_pkg::RegBrightMin: cfg_q.bright_min      <= wr_data;
				lbf_pkg::RegRampStep:  cfg_q.ramp_step       <= wr_data;
				lbf_pkg::RegHoldHigh:  cfg_q.hold_high_ticks <= wr_data;
				lbf_pkg::RegHoldLow:   cfg_q.hold_low_ticks  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/lbf_step.sv
// Next-state and result logic for one tick of the breathing fade.
// Purely combinational; depends on lbf_pkg for cfg_t, state_t and result_t.
module lbf_step (
	input  lbf_pkg::cfg_t   cfg,
	input  lbf_pkg::state_t cur,
	input  logic            night,
	output lbf_pkg::state_t nxt,
	output lbf_pkg::result_t res
);

	logic [lbf_pkg::LevelW-1:0] lvl;
	logic [lbf_pkg::LevelW-1:0] tc;
	logic [lbf_pkg::LevelW:0]   up_sum;
	lbf_pkg::phase_t            ph;
	logic                       wr;
	logic                       nc;

	always_comb begin
		lvl    = cur.level;
		tc     = cur.tick_count;
		ph     = cur.phase;
		wr     = 1'b0;
		nc     = 1'b0;
		nxt    = cur;
		up_sum = '0;

		if (cfg.enabled) begin
			// Track night level; a night-to-day edge darkens the LED
			if (cur.night_seen != night) begin
				nxt.night_seen = night;
				if (!night) begin
					ph  = lbf_pkg::PH_OFF;
					lvl = '0;
					wr  = 1'b1;
				end
			end

			tc = tc + 1'b1;

			// Clamp to max first, then min (min wins when min > max)
			if (lvl > cfg.bright_max) lvl = cfg.bright_max;
			if (lvl < cfg.bright_min) lvl = cfg.bright_min;

			// Start a new fade cycle
			if (ph == lbf_pkg::PH_OFF && night) begin
				tc = '0;
				ph = lbf_pkg::PH_UP;
				nc = 1'b1;
			end

			// Ramp up, saturating at full scale
			if (ph == lbf_pkg::PH_UP) begin
				up_sum = {1'b0, lvl} + {1'b0, cfg.ramp_step};
				lvl    = up_sum[lbf_pkg::LevelW] ? lbf_pkg::LevelTop
					: up_sum[lbf_pkg::LevelW-1:0];
				wr     = 1'b1;
				if (lvl >= cfg.bright_max) begin
					ph = lbf_pkg::PH_HOLD_HIGH;
					tc = '0;
				end
			end

			if (ph == lbf_pkg::PH_HOLD_HIGH && tc >= cfg.hold_high_ticks)
				ph = lbf_pkg::PH_DOWN;

			// Ramp down, saturating at zero
			if (ph == lbf_pkg::PH_DOWN) begin
				lvl = (cfg.ramp_step <= lvl) ? lvl - cfg.ramp_step : '0;
				wr  = 1'b1;
				if (lvl <= cfg.bright_min) begin
					ph = lbf_pkg::PH_HOLD_LOW;
					tc = '0;
				end
			end

			if (ph == lbf_pkg::PH_HOLD_LOW && tc >= cfg.hold_low_ticks)
				ph = lbf_pkg::PH_OFF;

			nxt.phase      = ph;
			nxt.level      = lvl;
			nxt.tick_count = tc;
		end

		res.brightness       = lvl;
		res.write_brightness = wr;
		res.new_color        = nc;
		res.phase            = ph;
	end

endmodule

>>> rtl/led_breathing_fade_controller.sv
// Top level of the LED breathing fade controller: input register, fade state, result register.
// Depends on lbf_pkg, lbf_cfg_regs and lbf_step.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------------
//   in       | in_valid / in_stall  | is_night
//   out      | out_valid / out_stall| brightness, write_brightness, new_color, phase
//   cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One tick per clock unless out_stall holds a full result register: a tick is captured in
// the input register, evaluated against the fade state in one pass of lbf_step, and lands
// in the result register when that register is free.
// The input register keeps accepting while a result waits; in_stall rises only when both
// the input register and a stalled result register are full.
// Reset clears the fade state and both valid flags and loads the configuration reset values.
module led_breathing_fade_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          is_night,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lbf_pkg::LevelW-1:0]    brightness,
	output logic                          write_brightness,
	output logic                          new_color,
	output logic [2:0]                    phase,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lbf_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [lbf_pkg::CfgDataW-1:0]  cfg_data
);

	lbf_pkg::cfg_t    cfg;
	lbf_pkg::state_t  state_q;
	lbf_pkg::state_t  state_nxt;
	lbf_pkg::result_t res;
	lbf_pkg::result_t res_q;
	logic             valid_s1;
	logic             night_s1;
	logic             out_valid_q;
	logic             out_free;
	logic             fire;
	logic             in_take;

	assign cfg_ready = 1'b1;

	lbf_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lbf_step u_step (
		.cfg   (cfg),
		.cur   (state_q),
		.night (night_s1),
		.nxt   (state_nxt),
		.res   (res)
	);

	// Handshake control
	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) night_s1 <= is_night;
	end

	// Fade state: advance once per evaluated tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= lbf_pkg::PH_OFF;
			state_q.level      <= '0;
			state_q.tick_count <= '0;
			state_q.night_seen <= 1'b0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) res_q <= res;
	end

	assign out_valid        = out_valid_q;
	assign brightness       = res_q.brightness;
	assign write_brightness = res_q.write_brightness;
	assign new_color        = res_q.new_color;
	assign phase            = res_q.phase;

`ifndef SYNTHESIS
	// A new fade cycle always ramps, so it always writes the brightness
	a_newcolor_writes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.new_color |-> res_q.write_brightness)
		else $error("new_color without write_brightness");

	// Back-pressure only when both stages are occupied and the output is stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a full pipeline");

	// A disabled tick leaves the fade state untouched
	a_disabled_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !cfg.enabled |=> $stable(state_q))
		else $error("fade state changed while disabled");
`endif

endmodule
